/* sv/alip_pkg.sv */
// Shared codes, states and controller/datapath link types for the insert-at-position list.
`timescale 1ns / 1ps

package alip_pkg;

    // Transaction modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_FWD    = 2'd1;
    localparam logic [1:0] MODE_REV    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_ELEMENT  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_single;  // latch a one-result transaction, apply insert if legal
        logic list_start;   // set up the listing walk
        logic list_emit;    // emit the element under the walk pointer
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;        // no element held
        logic at_last;      // the walk is on its final element
    } dp_sts_t;

endpackage

/* sv/alip_if.sv */
// Valid/ready channel interfaces for list requests and list results.
`timescale 1ns / 1ps

interface alip_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic signed [31:0] value;
    logic        [3:0]  position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

interface alip_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic signed [31:0] element;
    logic        [3:0]  count;
    logic               last;

    modport source (output valid, status, element, count, last, input ready);
    modport sink   (input valid, status, element, count, last, output ready);
endinterface

/* sv/alip_ctrl.sv */
// Controller state machine: handshakes, output valid and listing sequence.
`timescale 1ns / 1ps

module alip_ctrl import alip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_sts_t    sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    unique case (in_mode) inside
                        MODE_INSERT:
                        begin
                            cmd.load_single = 1'b1;
                            out_valid_next  = 1'b1;
                        end
                        MODE_FWD, MODE_REV:
                        begin
                            if (sts.empty)
                            begin
                                cmd.load_single = 1'b1;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LIST;
                            end
                        end
                        default:
                        begin
                            // unused mode: drop the transaction
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    cmd.list_emit  = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (in_mode == MODE_INSERT || (sts.empty &&
            (in_mode == MODE_FWD || in_mode == MODE_REV))) |=> out_valid_reg)
        else $error("one-result transaction did not raise output valid");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST && out_free && sts.at_last
            |=> state_reg == S_IDLE && out_valid_reg)
        else $error("listing did not return to idle after its final element");

    a_list_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> !in_ready)
        else $error("input taken while a listing is in progress");
`endif

endmodule

/* sv/alip_dp.sv */
// Datapath: element cells, element count, listing walk and output register.
`timescale 1ns / 1ps

module alip_dp import alip_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_sts_t            sts,
    input  logic        [1:0]  in_mode,
    input  logic signed [31:0] in_value,
    input  logic        [3:0]  in_position,
    output logic        [2:0]  status,
    output logic signed [31:0] element,
    output logic        [3:0]  count,
    output logic               last
);

    localparam int HW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = (HW > 4) ? HW : 4;

    logic signed [31:0] slots_reg  [CAPACITY];
    logic signed [31:0] slots_next [CAPACITY];
    logic [HW-1:0]      held_reg, held_next;
    logic [HW-1:0]      left_reg;
    logic [IW-1:0]      idx_reg;
    logic               reverse_reg;
    logic [2:0]         status_reg;
    logic signed [31:0] element_reg;
    logic [3:0]         count_reg;
    logic               last_reg;

    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      held_ext;
    logic               full;
    logic               bad_pos;
    logic               ins_ok;
    logic [2:0]         single_status;

    assign pos_ext  = CW'(in_position);
    assign held_ext = CW'(held_reg);
    assign full     = (held_reg == HW'(CAPACITY));
    assign bad_pos  = (pos_ext > held_ext);
    assign ins_ok   = cmd.load_single && (in_mode == MODE_INSERT) && !full && !bad_pos;

    assign sts.empty   = (held_reg == '0);
    assign sts.at_last = (left_reg == HW'(1));

    always_comb
    begin
        if (in_mode != MODE_INSERT)
        begin
            single_status = ST_EMPTY;
        end
        else if (full)
        begin
            single_status = ST_FULL;
        end
        else if (bad_pos)
        begin
            single_status = ST_BADPOS;
        end
        else
        begin
            single_status = ST_INSERTED;
        end
    end

    assign held_next = ins_ok ? held_reg + HW'(1) : held_reg;

    // Each cell takes the new value, its lower neighbour, or holds
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_ok && CW'(i) == pos_ext)
            begin
                slots_next[i] = in_value;
            end
            else if (ins_ok && CW'(i) > pos_ext)
            begin
                slots_next[i] = slots_reg[(i > 0) ? i - 1 : 0];
            end
            else
            begin
                slots_next[i] = slots_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slots_reg[i] <= slots_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            if (cmd.list_start)
            begin
                left_reg <= held_reg;
            end
            else if (cmd.list_emit)
            begin
                left_reg <= left_reg - HW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.list_start)
        begin
            reverse_reg <= (in_mode == MODE_REV);
            idx_reg     <= (in_mode == MODE_REV) ? IW'(held_reg - HW'(1)) : '0;
        end
        else if (cmd.list_emit)
        begin
            idx_reg <= reverse_reg ? idx_reg - IW'(1) : idx_reg + IW'(1);
        end

        if (cmd.load_single)
        begin
            status_reg  <= single_status;
            element_reg <= '0;
            count_reg   <= 4'(held_next);
            last_reg    <= 1'b1;
        end
        else if (cmd.list_emit)
        begin
            status_reg  <= ST_ELEMENT;
            element_reg <= slots_reg[idx_reg];
            count_reg   <= 4'(held_reg);
            last_reg    <= (left_reg == HW'(1));
        end
    end

    assign status  = status_reg;
    assign element = element_reg;
    assign count   = count_reg;
    assign last    = last_reg;

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(CAPACITY))
        else $error("element count exceeds capacity");

    a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_emit |-> left_reg != '0 && left_reg <= held_reg)
        else $error("element emitted with no element left in the walk");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> held_reg == $past(held_reg) + HW'(1) && status_reg == ST_INSERTED)
        else $error("accepted insert did not grow the list");
`endif

endmodule

/* sv/array_list_insert_at_position_unit.sv */
// Top level: ordered list with insert-at-position and streamed listing.
// An insert, a rejected insert or an empty listing gives its result in the cycle after accept.
// A listing first loads the walk, then moves its elements into the output register, one per cycle
// while the output is free. One-result transactions are taken every cycle while the output is free;
// no input is taken during a listing. An insert shifts the cells above its position together.
// Reset clears the element count and the output valid; element cells are not cleared.
`timescale 1ns / 1ps

module array_list_insert_at_position_unit import alip_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    alip_in_if.sink           in_ch,
    alip_out_if.source        out_ch
);

    // Command and status link between the controller and the datapath
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Controller: owns both handshakes and sequences each listing transaction
    alip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.mode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: element cells shift on insert; the output register holds one
    // result so the next transaction may be taken as that result is taken
    alip_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_mode     (in_ch.mode),
        .in_value    (in_ch.value),
        .in_position (in_ch.position),
        .status      (out_ch.status),
        .element     (out_ch.element),
        .count       (out_ch.count),
        .last        (out_ch.last)
    );

endmodule
